// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros: clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge out of reset
`define ASSERT_AT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be true at a rising edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/ist_pkg.sv =====
// ----------------------------------------------------------------------------
// ist_pkg
// Types and constants shared by the integer set table modules
// ----------------------------------------------------------------------------
package ist_pkg;

	localparam int CAPACITY_DEF = 64;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                operation;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               was_member;
		logic [6:0]         entry_count;
		logic signed [31:0] largest;
		logic signed [31:0] smallest;
		logic               is_empty;
		logic               status;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_FINISH
	} st_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan_rd;
		logic shift_init;
		logic shift_rd;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic rd_done;
		logic rd_busy;
		logic found;
		logic out_busy;
	} sts_t;

endpackage

// ===== rtl/ist_ram.sv =====
// ----------------------------------------------------------------------------
// ist_ram
// Generic RAM: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module ist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/ist_ctrl.sv =====
// ----------------------------------------------------------------------------
// ist_ctrl
// Sequencer for the set table: accept, scan, shift on remove, finish
// ----------------------------------------------------------------------------
module ist_ctrl
	import ist_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  op_t  in_op,
	input  sts_t sts,
	output cmd_t cmd
);

	st_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (in_op == OP_CLEAR) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!sts.rd_done) begin
					cmd.scan_rd = 1'b1;
				end else if (!sts.rd_busy) begin
					if (sts.op == OP_REMOVE && sts.found) begin
						cmd.shift_init = 1'b1;
						state_d        = ST_SHIFT;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SHIFT: begin
				if (!sts.rd_done) begin
					cmd.shift_rd = 1'b1;
				end else if (!sts.rd_busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/ist_dpath.sv =====
// ----------------------------------------------------------------------------
// ist_dpath
// Entry store, scan compare and min/max accumulators, count and result register
// ----------------------------------------------------------------------------
module ist_dpath
	import ist_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t in_data,
	input  cmd_t cmd,
	output sts_t sts,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data
);

	op_t                op_q;
	logic signed [31:0] value_q;
	logic [CW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;
	logic               rd_vld_s1;
	logic               rd_shift_s1;
	logic [AW-1:0]      rd_addr_s1;
	logic               found_q;
	logic [AW-1:0]      pos_q;
	logic               any_q;
	logic signed [31:0] max_q;
	logic signed [31:0] min_q;
	logic               out_valid_q;
	rsp_t               out_q;

	logic               re;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [31:0]        wdata;
	logic [31:0]        rdata;
	logic signed [31:0] elem;
	logic               room;
	logic               ins_new;
	logic               incl_v;
	logic [CW-1:0]      count_d;
	rsp_t               rsp_d;

	assign re    = cmd.scan_rd | cmd.shift_rd;
	assign elem  = $signed(rdata);
	assign room  = count_q < CW'(CAPACITY);
	assign ins_new = (op_q == OP_INSERT) && !found_q && room;

	// write port: shift moves an entry down one place, insert appends
	always_comb begin
		if (rd_vld_s1 && rd_shift_s1) begin
			we    = 1'b1;
			waddr = rd_addr_s1 - AW'(1);
			wdata = rdata;
		end else begin
			we    = cmd.commit && ins_new;
			waddr = count_q[AW-1:0];
			wdata = value_q;
		end
	end

	ist_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(rd_ptr_q[AW-1:0]),
		.rdata(rdata)
	);

	// control registers: read pointer, read pipe, count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			rd_vld_s1   <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= re;
			if (cmd.load) begin
				rd_ptr_q <= '0;
			end else if (cmd.shift_init) begin
				rd_ptr_q <= CW'(pos_q) + CW'(1);
			end else if (re) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end
			if (cmd.commit) begin
				count_q <= count_d;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture, read pipe payload and scan accumulators
	always_ff @(posedge clk) begin
		rd_addr_s1  <= rd_ptr_q[AW-1:0];
		rd_shift_s1 <= cmd.shift_rd;
		if (cmd.load) begin
			op_q    <= in_data.operation;
			value_q <= in_data.value;
			found_q <= 1'b0;
			any_q   <= 1'b0;
		end else if (rd_vld_s1 && !rd_shift_s1) begin
			// min/max over entries other than the request value
			if (elem == value_q) begin
				found_q <= 1'b1;
				pos_q   <= rd_addr_s1;
			end else begin
				any_q <= 1'b1;
				if (!any_q || elem > max_q) begin
					max_q <= elem;
				end
				if (!any_q || elem < min_q) begin
					min_q <= elem;
				end
			end
		end
		if (cmd.commit) begin
			out_q <= rsp_d;
		end
	end

	// result of the operation
	always_comb begin
		incl_v  = ((op_q == OP_INSERT) && (found_q || room)) ||
			((op_q == OP_LOOKUP) && found_q);
		count_d = count_q;
		rsp_d   = '0;
		unique case (op_q)
			OP_INSERT: count_d = ins_new ? count_q + CW'(1) : count_q;
			OP_REMOVE: count_d = found_q ? count_q - CW'(1) : count_q;
			OP_LOOKUP: count_d = count_q;
			OP_CLEAR:  count_d = '0;
			default:   count_d = count_q;
		endcase
		rsp_d.was_member  = (op_q != OP_CLEAR) && found_q;
		rsp_d.entry_count = 7'(count_d);
		rsp_d.is_empty    = (count_d == '0);
		rsp_d.status      = (op_q == OP_INSERT) && !found_q && !room;
		if (op_q == OP_CLEAR) begin
			rsp_d.largest  = '0;
			rsp_d.smallest = '0;
		end else if (any_q) begin
			rsp_d.largest  = (incl_v && value_q > max_q) ? value_q : max_q;
			rsp_d.smallest = (incl_v && value_q < min_q) ? value_q : min_q;
		end else if (incl_v) begin
			rsp_d.largest  = value_q;
			rsp_d.smallest = value_q;
		end else begin
			rsp_d.largest  = '0;
			rsp_d.smallest = '0;
		end
	end

	assign sts.op       = op_q;
	assign sts.rd_done  = (rd_ptr_q == count_q);
	assign sts.rd_busy  = rd_vld_s1;
	assign sts.found    = found_q;
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/integer_set_table.sv =====
// ----------------------------------------------------------------------------
// integer_set_table
// Set of distinct signed 32-bit integers with insert, remove, lookup, clear
// ----------------------------------------------------------------------------
// One request at a time. Entries sit in insertion order in a single-port-read
// RAM, and every insert, remove or lookup scans the stored entries through
// that one read port, one per cycle, to find the value and the largest and
// smallest entries. A remove that hits then moves the later entries down one
// place, again one per cycle through the same port. The next request is taken
// the cycle after the result is loaded. A new request is taken while the
// previous result still waits in the output register; loading the new result
// then waits until the previous one is taken. No clearing pass is needed
// after reset.
`include "assert_macros.svh"

module integer_set_table
	import ist_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	ist_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_op   (in_data.operation),
		.sts     (sts),
		.cmd     (cmd)
	);

	// entry store and result datapath
	ist_dpath #(
		.CAPACITY(CAPACITY)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	`ASSERT_AT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "request taken while busy")
	`ASSERT_NEVER(a_full_not_member, out_valid && out_data.status && out_data.was_member, "full status on member")
	`ASSERT_AT(a_empty_zero, out_valid && out_data.is_empty |-> out_data.largest == 0 && out_data.smallest == 0, "empty set with nonzero extremes")
	`ASSERT_AT(a_order, out_valid && !out_data.is_empty |-> $signed(out_data.largest) >= $signed(out_data.smallest), "largest below smallest")

endmodule

// ===== dv/integer_set_table_test.sv =====
// ----------------------------------------------------------------------------
// integer_set_table_test
// Self-checking bench for the integer set table
// ----------------------------------------------------------------------------
// A short table of directed requests covers the empty set, the signed
// extremes, duplicate inserts, removes at the front, middle and end, removes
// of absent values and clear. Random traffic follows in fill and drain
// episodes, so the table runs full and empty several times. Every result is
// compared field by field with a shadow copy of the set (typed rows with
// their own expected result), under three patterns of idling on both channels.
// ----------------------------------------------------------------------------
module integer_set_table_test;
	import ist_pkg::*;

	localparam int CAP          = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 343;
	localparam int QUIET_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 2 * CAP + 16;
	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	typedef struct packed {
		req_t req;
		logic typed;
		rsp_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;

	// shadow copy of the set
	logic signed [31:0] shadow_set [CAP];
	int shadow_count = 0;

	rsp_t awaited_rsp [$];
	plan_row_t directed_plan [$];

	int err_count = 0;
	int sent_count = 0;
	int rsp_count = 0;
	int full_drops = 0;
	int member_hits = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 17;
	int recv_idle_pct = 81;

	integer_set_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// apply one request to the shadow set and build its result
	function automatic rsp_t apply_set_op(req_t r);
		rsp_t res;
		logic hit;
		logic signed [31:0] hi;
		logic signed [31:0] lo;
		int pos;
		int i;
		res = '0;
		hit = 1'b0;
		hi = '0;
		lo = '0;
		pos = shadow_count;
		for (i = 0; i < shadow_count; i++) begin
			if (!hit && shadow_set[i] == r.value) begin
				hit = 1'b1;
				pos = i;
			end
		end
		unique case (r.operation)
			OP_INSERT: begin
				res.was_member = hit;
				if (!hit) begin
					if (shadow_count < CAP) begin
						shadow_set[shadow_count] = r.value;
						shadow_count++;
					end else begin
						res.status = 1'b1;
					end
				end
			end
			OP_REMOVE: begin
				res.was_member = hit;
				if (hit) begin
					for (i = pos; i < shadow_count - 1; i++)
						shadow_set[i] = shadow_set[i + 1];
					shadow_count--;
				end
			end
			OP_LOOKUP: res.was_member = hit;
			default: shadow_count = 0;
		endcase
		if (shadow_count > 0) begin
			hi = shadow_set[0];
			lo = shadow_set[0];
			for (i = 1; i < shadow_count; i++) begin
				if (shadow_set[i] > hi)
					hi = shadow_set[i];
				if (shadow_set[i] < lo)
					lo = shadow_set[i];
			end
		end
		res.largest = hi;
		res.smallest = lo;
		res.entry_count = shadow_count[6:0];
		res.is_empty = (shadow_count == 0);
		return res;
	endfunction

	// operand choice: stored values, extremes, a narrow pool, or anything
	function automatic logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 45 && shadow_count > 0)
			return shadow_set[$urandom_range(shadow_count - 1)];
		if (r < 60) begin
			case ($urandom_range(6))
				0: return S32_MAX;
				1: return S32_MIN;
				2: return S32_MAX - 1;
				3: return S32_MIN + 1;
				4: return -32'sd1;
				5: return 32'sd1;
				default: return 32'sd0;
			endcase
		end
		if (r < 80)
			return $signed(32'($urandom_range(95))) - 32'sd48;
		return $signed($urandom);
	endfunction

	task automatic plan_row(op_t op, logic signed [31:0] v);
		plan_row_t row;
		row = '0;
		row.req.operation = op;
		row.req.value = v;
		directed_plan.insert(directed_plan.size(), row);
	endtask

	task automatic plan_typed(op_t op, logic signed [31:0] v, logic was, logic [6:0] cnt,
			logic signed [31:0] hi, logic signed [31:0] lo, logic empty, logic st);
		plan_row_t row;
		row.req.operation = op;
		row.req.value = v;
		row.typed = 1'b1;
		row.want.was_member = was;
		row.want.entry_count = cnt;
		row.want.largest = hi;
		row.want.smallest = lo;
		row.want.is_empty = empty;
		row.want.status = st;
		directed_plan.insert(directed_plan.size(), row);
	endtask

	// drive one request, wait for it to be taken, then record its result
	task automatic send_item(req_t r, logic typed, rsp_t want);
		rsp_t predicted;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		predicted = apply_set_op(r);
		if (predicted.status)
			full_drops++;
		if (predicted.was_member)
			member_hits++;
		awaited_rsp.insert(awaited_rsp.size(), typed ? want : predicted);
		sent_count++;
	endtask

	// sender holds off until every result is back
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_rsp.size() != 0);
	endtask

	task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
			err_count++;
		end
	endtask

	// receiver back-pressure
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// result checking
	always @(posedge clk) begin : result_check
		rsp_t want;
		if (out_valid && out_ready) begin
			rsp_count++;
			if (awaited_rsp.size() == 0) begin
				$display("%0t: result with none expected: %h", $time, out_data);
				err_count++;
			end else begin
				want = awaited_rsp.pop_front();
				report_field("was_member", want.was_member, out_data.was_member);
				report_field("entry_count", want.entry_count, out_data.entry_count);
				report_field("largest", want.largest, out_data.largest);
				report_field("smallest", want.smallest, out_data.smallest);
				report_field("is_empty", want.is_empty, out_data.is_empty);
				report_field("status", want.status, out_data.status);
			end
		end
	end

	// cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("%0t: no handshake for %0d cycles, %0d results outstanding",
			$time, QUIET_LIMIT, awaited_rsp.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		req_t r;
		plan_row_t row;
		logic filling;
		int overflow_left;
		int pick;
		int phase;
		int n;

		filling = 1'b1;
		overflow_left = $urandom_range(3, 10);

		// directed table: empty set, extremes, duplicates, removes, clear
		plan_typed(OP_LOOKUP, 32'sd0, 1'b0, 7'd0, 32'sd0, 32'sd0, 1'b1, 1'b0);
		plan_typed(OP_REMOVE, 32'sd5, 1'b0, 7'd0, 32'sd0, 32'sd0, 1'b1, 1'b0);
		plan_typed(OP_CLEAR, -32'sd1, 1'b0, 7'd0, 32'sd0, 32'sd0, 1'b1, 1'b0);
		plan_typed(OP_INSERT, S32_MAX, 1'b0, 7'd1, S32_MAX, S32_MAX, 1'b0, 1'b0);
		plan_typed(OP_INSERT, S32_MIN, 1'b0, 7'd2, S32_MAX, S32_MIN, 1'b0, 1'b0);
		plan_typed(OP_INSERT, S32_MAX, 1'b1, 7'd2, S32_MAX, S32_MIN, 1'b0, 1'b0);
		plan_typed(OP_LOOKUP, S32_MIN, 1'b1, 7'd2, S32_MAX, S32_MIN, 1'b0, 1'b0);
		plan_row(OP_INSERT, 32'sd0);
		plan_row(OP_INSERT, -32'sd1);
		plan_row(OP_INSERT, 32'sh55555555);
		plan_row(OP_INSERT, 32'shaaaaaaaa);
		plan_row(OP_LOOKUP, 32'sh12345678);
		plan_row(OP_REMOVE, S32_MAX);
		plan_row(OP_REMOVE, -32'sd1);
		plan_row(OP_REMOVE, 32'shaaaaaaaa);
		plan_row(OP_LOOKUP, S32_MAX);
		plan_row(OP_REMOVE, 32'sd12345);
		plan_row(OP_INSERT, 32'sd1);
		plan_typed(OP_CLEAR, 32'sd0, 1'b0, 7'd0, 32'sd0, 32'sd0, 1'b1, 1'b0);
		plan_typed(OP_LOOKUP, 32'sd0, 1'b0, 7'd0, 32'sd0, 32'sd0, 1'b1, 1'b0);
		plan_row(OP_INSERT, 32'sd42);
		plan_row(OP_REMOVE, 32'sd42);
		plan_typed(OP_REMOVE, 32'sd42, 1'b0, 7'd0, 32'sd0, 32'sd0, 1'b1, 1'b0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			row = directed_plan[i];
			send_item(row.req, row.typed, row.want);
		end
		hold_until_drained();

		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 81 : 0;
			recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 17 : 0;
			for (n = 0; n < RANDOM_ITEMS; n++) begin
				// switch between growing the set and emptying it
				if (filling && shadow_count == CAP) begin
					if (overflow_left == 0)
						filling = 1'b0;
					else
						overflow_left--;
				end else if (!filling && shadow_count == 0) begin
					filling = 1'b1;
					overflow_left = $urandom_range(3, 10);
				end
				pick = $urandom_range(99);
				if (filling) begin
					if (pick < 78) begin
						r.operation = OP_INSERT;
						r.value = ($urandom_range(99) < 80) ? $signed($urandom) : pick_value();
					end else begin
						r.operation = (pick < 90) ? OP_LOOKUP : OP_REMOVE;
						r.value = pick_value();
					end
				end else if (pick < 6) begin
					// noise: anything at all
					r.operation = op_t'($urandom_range(3));
					r.value = $signed($urandom);
				end else begin
					r.operation = (pick < 71) ? OP_REMOVE : (pick < 81) ? OP_INSERT :
						(pick < 96) ? OP_LOOKUP : OP_CLEAR;
					r.value = (r.operation == OP_CLEAR) ? $signed($urandom) : pick_value();
				end
				send_item(r, 1'b0, '0);
				if ($urandom_range(49) == 0)
					hold_until_drained();
			end
			hold_until_drained();
		end

		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests (%0d directed) and %0d results under three idle patterns",
			sent_count, directed_plan.size(), rsp_count);
		$display("saw %0d member hits and %0d inserts dropped on a full table",
			member_hits, full_drops);
		if (err_count == 0 && awaited_rsp.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
